// ----- rtl/cpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Convex polygon clipper package
// Shared item types, command codes and controller states.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int IN_COORD_W = 12;
    localparam int OUT_W      = 16;
    localparam int OUT_MAX    = 65535;
    localparam int CFG_W      = 5;
    localparam int SLOT_W     = 4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CLIP = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [SLOT_W-1:0]     vertex_slot;
        logic [IN_COORD_W-1:0] point_a_x;
        logic [IN_COORD_W-1:0] point_a_y;
        logic [IN_COORD_W-1:0] point_b_x;
        logic [IN_COORD_W-1:0] point_b_y;
    } req_t;

    typedef struct packed {
        logic             visible;
        logic [OUT_W-1:0] clip_start_x;
        logic [OUT_W-1:0] clip_start_y;
        logic [OUT_W-1:0] clip_end_x;
        logic [OUT_W-1:0] clip_end_y;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHAIN,
        S_DIV,
        S_DONE
    } state_t;

endpackage

// ----- rtl/cpc_cell.sv -----
// ----------------------------------------------------------------------------
// Clipper edge cell
// Holds one polygon vertex and tightens the entering and leaving parameters
// of the segment against the edge that starts at it, in three stages.
// ----------------------------------------------------------------------------
module cpc_cell #(
    parameter int COORD_BITS = 12,
    localparam int DW = COORD_BITS + 1,
    localparam int PW = 2 * DW,
    localparam int NW = PW + 1,
    localparam int FW = 2 * NW
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [COORD_BITS-1:0]        wr_x,
    input  logic [COORD_BITS-1:0]        wr_y,
    output logic [COORD_BITS-1:0]        vtx_x,
    output logic [COORD_BITS-1:0]        vtx_y,
    input  logic [COORD_BITS-1:0]        nxt_x,
    input  logic [COORD_BITS-1:0]        nxt_y,
    input  logic                         active,
    input  logic [COORD_BITS-1:0]        ax,
    input  logic [COORD_BITS-1:0]        ay,
    input  logic signed [DW-1:0]         dx,
    input  logic signed [DW-1:0]         dy,
    input  logic                         tin_valid,
    input  logic                         tin_ok,
    input  logic signed [NW-1:0]         tin_en,
    input  logic signed [NW-1:0]         tin_ed,
    input  logic signed [NW-1:0]         tin_ln,
    input  logic signed [NW-1:0]         tin_ld,
    output logic                         tout_valid,
    output logic                         tout_ok,
    output logic signed [NW-1:0]         tout_en,
    output logic signed [NW-1:0]         tout_ed,
    output logic signed [NW-1:0]         tout_ln,
    output logic signed [NW-1:0]         tout_ld
);

    logic [COORD_BITS-1:0] vx_reg;
    logic [COORD_BITS-1:0] vy_reg;

    logic signed [DW-1:0] ex;
    logic signed [DW-1:0] ey;
    logic signed [DW-1:0] wx;
    logic signed [DW-1:0] wy;

    logic                 s1_valid_reg;
    logic                 s1_ok_reg;
    logic signed [NW-1:0] s1_en_reg;
    logic signed [NW-1:0] s1_ed_reg;
    logic signed [NW-1:0] s1_ln_reg;
    logic signed [NW-1:0] s1_ld_reg;
    logic signed [PW-1:0] s1_p1_reg;
    logic signed [PW-1:0] s1_p2_reg;
    logic signed [PW-1:0] s1_p3_reg;
    logic signed [PW-1:0] s1_p4_reg;

    logic signed [NW-1:0] nd;
    logic signed [NW-1:0] np;
    logic signed [NW-1:0] tn;
    logic signed [NW-1:0] td;

    logic                 s2_valid_reg;
    logic                 s2_ok_reg;
    logic signed [NW-1:0] s2_en_reg;
    logic signed [NW-1:0] s2_ed_reg;
    logic signed [NW-1:0] s2_ln_reg;
    logic signed [NW-1:0] s2_ld_reg;
    logic                 s2_ndz_reg;
    logic                 s2_ndp_reg;
    logic                 s2_npn_reg;
    logic signed [NW-1:0] s2_tn_reg;
    logic signed [NW-1:0] s2_td_reg;
    logic signed [FW-1:0] s2_a_reg;
    logic signed [FW-1:0] s2_b_reg;
    logic signed [FW-1:0] s2_c_reg;
    logic signed [FW-1:0] s2_d_reg;

    logic signed [FW:0]   diff_p;
    logic signed [FW:0]   diff_q;

    logic                 ok_next;
    logic signed [NW-1:0] en_next;
    logic signed [NW-1:0] ed_next;
    logic signed [NW-1:0] ln_next;
    logic signed [NW-1:0] ld_next;

    logic                 out_valid_reg;
    logic                 out_ok_reg;
    logic signed [NW-1:0] out_en_reg;
    logic signed [NW-1:0] out_ed_reg;
    logic signed [NW-1:0] out_ln_reg;
    logic signed [NW-1:0] out_ld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vx_reg <= wr_x;
            vy_reg <= wr_y;
        end
    end

    assign vtx_x = vx_reg;
    assign vtx_y = vy_reg;

    assign ex = $signed({1'b0, nxt_x}) - $signed({1'b0, vx_reg});
    assign ey = $signed({1'b0, nxt_y}) - $signed({1'b0, vy_reg});
    assign wx = $signed({1'b0, ax}) - $signed({1'b0, vx_reg});
    assign wy = $signed({1'b0, ay}) - $signed({1'b0, vy_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= tin_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg <= tin_ok;
        s1_en_reg <= tin_en;
        s1_ed_reg <= tin_ed;
        s1_ln_reg <= tin_ln;
        s1_ld_reg <= tin_ld;
        s1_p1_reg <= ey * dx;
        s1_p2_reg <= ex * dy;
        s1_p3_reg <= ey * wx;
        s1_p4_reg <= ex * wy;
    end

    assign nd = s1_p2_reg - s1_p1_reg;
    assign np = s1_p4_reg - s1_p3_reg;
    assign tn = (nd > 0) ? -np : np;
    assign td = (nd < 0) ? -nd : nd;

    always_ff @(posedge clk)
    begin
        s2_ok_reg  <= s1_ok_reg;
        s2_en_reg  <= s1_en_reg;
        s2_ed_reg  <= s1_ed_reg;
        s2_ln_reg  <= s1_ln_reg;
        s2_ld_reg  <= s1_ld_reg;
        s2_ndz_reg <= (nd == 0);
        s2_ndp_reg <= (nd > 0);
        s2_npn_reg <= (np < 0);
        s2_tn_reg  <= tn;
        s2_td_reg  <= td;
        s2_a_reg   <= tn * s1_ld_reg;
        s2_b_reg   <= s1_ln_reg * td;
        s2_c_reg   <= tn * s1_ed_reg;
        s2_d_reg   <= s1_en_reg * td;
    end

    assign diff_p = s2_a_reg - s2_b_reg;
    assign diff_q = s2_c_reg - s2_d_reg;

    always_comb
    begin
        ok_next = s2_ok_reg;
        en_next = s2_en_reg;
        ed_next = s2_ed_reg;
        ln_next = s2_ln_reg;
        ld_next = s2_ld_reg;
        if (active && s2_ok_reg)
        begin
            if (s2_ndz_reg)
            begin
                if (s2_npn_reg)
                begin
                    ok_next = 1'b0;
                end
            end
            else if (s2_ndp_reg)
            begin
                if (diff_p > 0)
                begin
                    ok_next = 1'b0;
                end
                else if (diff_q > 0)
                begin
                    en_next = s2_tn_reg;
                    ed_next = s2_td_reg;
                end
            end
            else
            begin
                if (diff_q < 0)
                begin
                    ok_next = 1'b0;
                end
                else if (diff_p < 0)
                begin
                    ln_next = s2_tn_reg;
                    ld_next = s2_td_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_ok_reg <= ok_next;
        out_en_reg <= en_next;
        out_ed_reg <= ed_next;
        out_ln_reg <= ln_next;
        out_ld_reg <= ld_next;
    end

    assign tout_valid = out_valid_reg;
    assign tout_ok    = out_ok_reg;
    assign tout_en    = out_en_reg;
    assign tout_ed    = out_ed_reg;
    assign tout_ln    = out_ln_reg;
    assign tout_ld    = out_ld_reg;

endmodule

// ----- rtl/cpc_lane.sv -----
// ----------------------------------------------------------------------------
// Clipper endpoint lane
// Forms one clipped coordinate a + (num/den)*d in fixed point, rounded to
// nearest, with a restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpc_lane #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 4,
    localparam int DW  = COORD_BITS + 1,
    localparam int NW  = 2 * DW + 1,
    localparam int SW  = NW + DW + 1,
    localparam int XW  = SW + FRAC_BITS + 1,
    localparam int QB  = COORD_BITS + FRAC_BITS + 1,
    localparam int RW  = NW + 1,
    localparam int CW  = $clog2(QB + 1),
    localparam int QXW = QB + cpc_pkg::OUT_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [COORD_BITS-1:0]        a,
    input  logic signed [DW-1:0]         d,
    input  logic signed [NW-1:0]         num,
    input  logic signed [NW-1:0]         den,
    output logic                         done,
    output logic [cpc_pkg::OUT_W-1:0]    value
);

    logic                 mul_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [CW-1:0]        cnt_reg;

    logic signed [SW-1:0] ad_reg;
    logic signed [SW-1:0] nd_reg;
    logic signed [NW-1:0] den_reg;
    logic [RW-1:0]        rem_reg;
    logic [RW-1:0]        m_reg;
    logic [QB-1:0]        qsh_reg;

    logic signed [SW-1:0] sum;
    logic [XW-1:0]        xval;
    logic [RW:0]          trial;
    logic [RW:0]          diff;
    logic                 qbit;
    logic [RW-1:0]        rem_next;
    logic [QXW-1:0]       qext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            mul_reg  <= 1'b1;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (mul_reg)
        begin
            mul_reg <= 1'b0;
            run_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(QB - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign sum  = ad_reg + nd_reg;
    assign xval = ({{(FRAC_BITS + 1){1'b0}}, sum} << (FRAC_BITS + 1))
                  + XW'($unsigned(den_reg));

    assign trial    = {rem_reg, qsh_reg[QB-1]};
    assign diff     = trial - {1'b0, m_reg};
    assign qbit     = (trial >= {1'b0, m_reg});
    assign rem_next = qbit ? diff[RW-1:0] : trial[RW-1:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ad_reg  <= $signed({1'b0, a}) * den;
            nd_reg  <= num * d;
            den_reg <= den;
        end
        else if (mul_reg)
        begin
            rem_reg <= RW'(xval >> QB);
            qsh_reg <= xval[QB-1:0];
            m_reg   <= {den_reg, 1'b0};
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            qsh_reg <= {qsh_reg[QB-2:0], qbit};
        end
    end

    assign qext  = {{cpc_pkg::OUT_W{1'b0}}, qsh_reg};
    assign value = (qext > QXW'(cpc_pkg::OUT_MAX)) ? cpc_pkg::OUT_W'(cpc_pkg::OUT_MAX)
                                                   : qext[cpc_pkg::OUT_W-1:0];
    assign done  = done_reg;

endmodule

// ----- rtl/convex_polygon_line_clipper.sv -----
// ----------------------------------------------------------------------------
// Convex polygon line clipper
// Clips segments against a counterclockwise convex polygon held in a row
// of edge cells, then forms the clipped endpoints in fixed point.
// ----------------------------------------------------------------------------
// Items enter on req_data with req_valid and req_stall; results leave on
// rsp_data with rsp_valid and rsp_stall. The vertex count is written on the
// cfg channel, which is always ready.
// A load item writes one vertex and gives no result. A clip item passes
// through the registered stages of each cell in the row, then the four
// endpoint lanes run one quotient bit per cycle. One clip item is in flight
// at a time and req_stall is high meanwhile.
// The result sits in an output register, so the next item is accepted while
// the receiver stalls; a new result waits until that register is free.
// Reset clears the vertex count and all control state; vertex contents are
// undefined until written.
// ----------------------------------------------------------------------------
module convex_polygon_line_clipper #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 12,
    parameter int FRAC_BITS    = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  cpc_pkg::req_t             req_data,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output cpc_pkg::rsp_t             rsp_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cpc_pkg::CFG_W-1:0] cfg_data
);

    localparam int DW  = COORD_BITS + 1;
    localparam int NW  = 2 * DW + 1;
    localparam int FW  = 2 * NW;
    localparam int NCW = $clog2(MAX_VERTICES + 1);

    cpc_pkg::state_t state_reg;
    cpc_pkg::state_t state_next;

    logic [cpc_pkg::CFG_W-1:0] vcount_reg;
    logic [NCW-1:0]            n_eff;

    logic                  accept;
    logic                  is_clip;
    logic [COORD_BITS-1:0] in_ax;
    logic [COORD_BITS-1:0] in_ay;
    logic [COORD_BITS-1:0] in_bx;
    logic [COORD_BITS-1:0] in_by;

    logic [COORD_BITS-1:0] ax_reg;
    logic [COORD_BITS-1:0] ay_reg;
    logic signed [DW-1:0]  dx_reg;
    logic signed [DW-1:0]  dy_reg;
    logic                  head_valid_reg;
    logic                  head_ok_reg;

    logic [COORD_BITS-1:0] vx [0:MAX_VERTICES-1];
    logic [COORD_BITS-1:0] vy [0:MAX_VERTICES-1];

    logic                 t_valid [0:MAX_VERTICES];
    logic                 t_ok    [0:MAX_VERTICES];
    logic signed [NW-1:0] t_en    [0:MAX_VERTICES];
    logic signed [NW-1:0] t_ed    [0:MAX_VERTICES];
    logic signed [NW-1:0] t_ln    [0:MAX_VERTICES];
    logic signed [NW-1:0] t_ld    [0:MAX_VERTICES];

    logic                 tail_valid;
    logic                 okf_reg;
    logic signed [FW-1:0] fa_reg;
    logic signed [FW-1:0] fb_reg;
    logic                 visible;

    logic [3:0]                lane_done;
    logic [cpc_pkg::OUT_W-1:0] lane_val [0:3];

    logic          rsp_free;
    logic          rsp_load;
    logic          rsp_valid_reg;
    cpc_pkg::rsp_t rsp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
        end
        else if (cfg_valid)
        begin
            vcount_reg <= cfg_data;
        end
    end

    assign n_eff = (32'(vcount_reg) > MAX_VERTICES) ? NCW'(MAX_VERTICES)
                                                    : NCW'(vcount_reg);

    assign accept  = req_valid && !req_stall;
    assign is_clip = (req_data.cmd == cpc_pkg::CMD_CLIP);
    assign in_ax   = COORD_BITS'(req_data.point_a_x);
    assign in_ay   = COORD_BITS'(req_data.point_a_y);
    assign in_bx   = COORD_BITS'(req_data.point_b_x);
    assign in_by   = COORD_BITS'(req_data.point_b_y);

    always_ff @(posedge clk)
    begin
        if (accept && is_clip)
        begin
            ax_reg <= in_ax;
            ay_reg <= in_ay;
            dx_reg <= $signed({1'b0, in_bx}) - $signed({1'b0, in_ax});
            dy_reg <= $signed({1'b0, in_by}) - $signed({1'b0, in_ay});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            head_ok_reg    <= 1'b0;
        end
        else
        begin
            head_valid_reg <= accept && is_clip;
            head_ok_reg    <= (32'(n_eff) >= 3);
        end
    end

    assign t_valid[0] = head_valid_reg;
    assign t_ok[0]    = head_ok_reg;
    assign t_en[0]    = '0;
    assign t_ed[0]    = NW'(1);
    assign t_ln[0]    = NW'(1);
    assign t_ld[0]    = NW'(1);

    for (genvar k = 0; k < MAX_VERTICES; k++)
    begin : g_cell
        logic                  wr_en;
        logic                  active;
        logic [COORD_BITS-1:0] nxt_x;
        logic [COORD_BITS-1:0] nxt_y;

        assign wr_en  = accept && !is_clip && (32'(req_data.vertex_slot) == k);
        assign active = (32'(n_eff) > k);

        if (k == MAX_VERTICES - 1)
        begin : g_last
            assign nxt_x = vx[0];
            assign nxt_y = vy[0];
        end
        else
        begin : g_mid
            assign nxt_x = (32'(n_eff) == k + 1) ? vx[0] : vx[k+1];
            assign nxt_y = (32'(n_eff) == k + 1) ? vy[0] : vy[k+1];
        end

        cpc_cell #(
            .COORD_BITS(COORD_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .wr_en      (wr_en),
            .wr_x       (in_ax),
            .wr_y       (in_ay),
            .vtx_x      (vx[k]),
            .vtx_y      (vy[k]),
            .nxt_x      (nxt_x),
            .nxt_y      (nxt_y),
            .active     (active),
            .ax         (ax_reg),
            .ay         (ay_reg),
            .dx         (dx_reg),
            .dy         (dy_reg),
            .tin_valid  (t_valid[k]),
            .tin_ok     (t_ok[k]),
            .tin_en     (t_en[k]),
            .tin_ed     (t_ed[k]),
            .tin_ln     (t_ln[k]),
            .tin_ld     (t_ld[k]),
            .tout_valid (t_valid[k+1]),
            .tout_ok    (t_ok[k+1]),
            .tout_en    (t_en[k+1]),
            .tout_ed    (t_ed[k+1]),
            .tout_ln    (t_ln[k+1]),
            .tout_ld    (t_ld[k+1])
        );
    end

    assign tail_valid = t_valid[MAX_VERTICES];

    always_ff @(posedge clk)
    begin
        if (tail_valid)
        begin
            okf_reg <= t_ok[MAX_VERTICES];
            fa_reg  <= t_en[MAX_VERTICES] * t_ld[MAX_VERTICES];
            fb_reg  <= t_ln[MAX_VERTICES] * t_ed[MAX_VERTICES];
        end
    end

    assign visible = okf_reg && !(fa_reg > fb_reg);

    cpc_lane #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_sx (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tail_valid),
        .a     (ax_reg),
        .d     (dx_reg),
        .num   (t_en[MAX_VERTICES]),
        .den   (t_ed[MAX_VERTICES]),
        .done  (lane_done[0]),
        .value (lane_val[0])
    );

    cpc_lane #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_sy (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tail_valid),
        .a     (ay_reg),
        .d     (dy_reg),
        .num   (t_en[MAX_VERTICES]),
        .den   (t_ed[MAX_VERTICES]),
        .done  (lane_done[1]),
        .value (lane_val[1])
    );

    cpc_lane #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_ex (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tail_valid),
        .a     (ax_reg),
        .d     (dx_reg),
        .num   (t_ln[MAX_VERTICES]),
        .den   (t_ld[MAX_VERTICES]),
        .done  (lane_done[2]),
        .value (lane_val[2])
    );

    cpc_lane #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_ey (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tail_valid),
        .a     (ay_reg),
        .d     (dy_reg),
        .num   (t_ln[MAX_VERTICES]),
        .den   (t_ld[MAX_VERTICES]),
        .done  (lane_done[3]),
        .value (lane_val[3])
    );

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cpc_pkg::S_IDLE:
            begin
                if (accept && is_clip)
                begin
                    state_next = cpc_pkg::S_CHAIN;
                end
            end
            cpc_pkg::S_CHAIN:
            begin
                if (tail_valid)
                begin
                    state_next = cpc_pkg::S_DIV;
                end
            end
            cpc_pkg::S_DIV:
            begin
                if (&lane_done)
                begin
                    state_next = cpc_pkg::S_DONE;
                end
            end
            cpc_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = cpc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cpc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        rsp_load  = 1'b0;
        case (state_reg)
            cpc_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
            end
            cpc_pkg::S_DONE:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpc_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg.visible      <= visible;
            rsp_reg.clip_start_x <= visible ? lane_val[0] : '0;
            rsp_reg.clip_start_y <= visible ? lane_val[1] : '0;
            rsp_reg.clip_end_x   <= visible ? lane_val[2] : '0;
            rsp_reg.clip_end_y   <= visible ? lane_val[3] : '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.visible) |->
        (rsp_data.clip_start_x == '0 && rsp_data.clip_start_y == '0 &&
         rsp_data.clip_end_x == '0 && rsp_data.clip_end_y == '0))
        else $error("rejected item carries nonzero coordinates");

    a_tail_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid |-> (state_reg == cpc_pkg::S_CHAIN))
        else $error("cell row output outside chain phase");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == cpc_pkg::S_DONE))
        else $error("result appeared without a finished item");

endmodule

// ----- tb/tb_convex_polygon_line_clipper.sv -----
// ----------------------------------------------------------------------------
// Convex polygon line clipper testbench
// Loads convex polygons of several sizes, sets the vertex count between
// phases and sends directed and random segments. A scoreboard predicts every
// clipped segment with exact fractions and checks the results in order.
// ----------------------------------------------------------------------------
module tb_convex_polygon_line_clipper;

    class clip_scoreboard;
        logic [11:0]            poly_x [16];
        logic [11:0]            poly_y [16];
        logic [4:0]             corner_count;
        cpc_pkg::rsp_t          pending [$];
        int                     errors;

        function new();
            corner_count = 0;
            errors = 0;
            for (int i = 0; i < 16; i++)
            begin
                poly_x[i] = 0;
                poly_y[i] = 0;
            end
        endfunction

        function int sign_of(longint v);
            return (v > 0) - (v < 0);
        endfunction

        // Sign of an/ad - bn/bd with positive denominators.
        function int compare_ratio(longint an, longint ad, longint bn, longint bd);
            logic signed [127:0] lhs;
            logic signed [127:0] rhs;
            lhs = 128'(an) * 128'(bd);
            rhs = 128'(bn) * 128'(ad);
            return (lhs > rhs) - (lhs < rhs);
        endfunction

        function logic [15:0] to_fixed(longint p0, longint d, longint num, longint den);
            longint q;
            longint n;
            longint m;
            longint r;
            longint v;
            q = num * d * 16;
            n = 2 * q + den;
            m = 2 * den;
            if (n >= 0)
                r = n / m;
            else
                r = -((-n + m - 1) / m);
            v = p0 * 16 + r;
            if (v < 0)
                v = 0;
            if (v > cpc_pkg::OUT_MAX)
                v = cpc_pkg::OUT_MAX;
            return 16'(v);
        endfunction

        function void note_item(cpc_pkg::req_t it);
            longint ax, ay, dx, dy, en, ed, ln, ld, vx, vy, ex, ey, nd, np, tn, td;
            int            n;
            int            j;
            bit            ok;
            cpc_pkg::rsp_t r;
            if (it.cmd == cpc_pkg::CMD_LOAD)
            begin
                poly_x[it.vertex_slot] = it.point_a_x;
                poly_y[it.vertex_slot] = it.point_a_y;
                return;
            end
            ax = longint'(it.point_a_x);
            ay = longint'(it.point_a_y);
            dx = longint'(it.point_b_x) - ax;
            dy = longint'(it.point_b_y) - ay;
            en = 0; ed = 1; ln = 1; ld = 1;
            n = corner_count > 16 ? 16 : int'(corner_count);
            ok = n >= 3;
            for (int i = 0; ok && i < n; i++)
            begin
                j = (i + 1 == n) ? 0 : i + 1;
                vx = longint'(poly_x[i]);
                vy = longint'(poly_y[i]);
                ex = longint'(poly_x[j]) - vx;
                ey = longint'(poly_y[j]) - vy;
                nd = -ey * dx + ex * dy;
                np = -ey * (ax - vx) + ex * (ay - vy);
                if (nd == 0)
                begin
                    if (np < 0)
                        ok = 0;
                end
                else if (nd > 0)
                begin
                    tn = -np; td = nd;
                    if (compare_ratio(tn, td, ln, ld) > 0)
                        ok = 0;
                    else if (compare_ratio(tn, td, en, ed) > 0)
                    begin
                        en = tn; ed = td;
                    end
                end
                else
                begin
                    tn = np; td = -nd;
                    if (compare_ratio(tn, td, en, ed) < 0)
                        ok = 0;
                    else if (compare_ratio(tn, td, ln, ld) < 0)
                    begin
                        ln = tn; ld = td;
                    end
                end
            end
            if (ok && compare_ratio(en, ed, ln, ld) > 0)
                ok = 0;
            r = '0;
            if (ok)
            begin
                r.visible = 1'b1;
                r.clip_start_x = to_fixed(ax, dx, en, ed);
                r.clip_start_y = to_fixed(ay, dy, en, ed);
                r.clip_end_x = to_fixed(ax, dx, ln, ld);
                r.clip_end_y = to_fixed(ay, dy, ln, ld);
            end
            pending.push_back(r);
        endfunction

        function void check_result(cpc_pkg::rsp_t got);
            cpc_pkg::rsp_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.visible !== want.visible || got.clip_start_x !== want.clip_start_x ||
                got.clip_start_y !== want.clip_start_y ||
                got.clip_end_x !== want.clip_end_x || got.clip_end_y !== want.clip_end_y)
            begin
                $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    cpc_pkg::req_t req_data;
    logic          rsp_valid;
    logic          rsp_stall;
    cpc_pkg::rsp_t rsp_data;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [4:0]    cfg_data;

    clip_scoreboard board;
    bit         hold_off;
    bit         sending_done;
    logic [11:0] shape_x [16];
    logic [11:0] shape_y [16];

    convex_polygon_line_clipper dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial clk = 0;
    always #6 clk = ~clk;

    function int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 90);
        return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
    endfunction

    task automatic send_item(cpc_pkg::req_t it);
        int g;
        g = gap_length();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_item(it);
    endtask

    task automatic write_count(logic [4:0] value);
        req_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.corner_count = value;
    endtask

    task automatic send_load(int slot, int x, int y);
        cpc_pkg::req_t it;
        it = '0;
        it.cmd = cpc_pkg::CMD_LOAD;
        it.vertex_slot = 4'(slot);
        it.point_a_x = 12'(x);
        it.point_a_y = 12'(y);
        it.point_b_x = 12'($urandom);
        it.point_b_y = 12'($urandom);
        send_item(it);
    endtask

    task automatic send_clip(int ax, int ay, int bx, int by);
        cpc_pkg::req_t it;
        it.cmd = cpc_pkg::CMD_CLIP;
        it.vertex_slot = 4'($urandom);
        it.point_a_x = 12'(ax);
        it.point_a_y = 12'(ay);
        it.point_b_x = 12'(bx);
        it.point_b_y = 12'(by);
        send_item(it);
    endtask

    // Random convex polygon: points on a circle at increasing angles.
    task automatic load_polygon(int n);
        real ang;
        real cx;
        real cy;
        real rad;
        cx = $urandom_range(600, 3500);
        cy = $urandom_range(600, 3500);
        rad = $urandom_range(50, 590);
        if ($urandom_range(0, 3) == 0)
        begin
            cx = 2048; cy = 2048; rad = 2047;
        end
        for (int i = 0; i < n; i++)
        begin
            ang = 6.2831853 * (i + ($urandom_range(0, 60) / 100.0)) / n;
            shape_x[i] = 12'(int'(cx + rad * $cos(ang)));
            shape_y[i] = 12'(int'(cy + rad * $sin(ang)));
            send_load(i, int'(shape_x[i]), int'(shape_y[i]));
        end
    endtask

    function int near_coord(int c);
        int v;
        v = c + $urandom_range(0, 800) - 400;
        return v < 0 ? 0 : (v > 4095 ? 4095 : v);
    endfunction

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_result(rsp_data);

    always @(posedge clk)
    begin
        if (hold_off || sending_done)
            rsp_stall <= hold_off;
        else if ($urandom_range(0, 29) == 0)
            rsp_stall <= 1'b1;
        else if ($urandom_range(0, 2) == 0)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= rsp_stall && $urandom_range(0, 5) != 0;
    end

    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int n;
        int k;
        board = new();
        rst_n = 0;
        req_valid = 0;
        req_data = '0;
        rsp_stall = 0;
        cfg_valid = 0;
        cfg_data = 0;
        hold_off = 0;
        sending_done = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: square, count zero, clipping across, degenerate segment.
        send_load(0, 0, 0);
        send_load(1, 4095, 0);
        send_load(2, 4095, 4095);
        send_load(3, 0, 4095);
        send_clip(10, 10, 20, 20);
        write_count(5'd4);
        send_clip(0, 0, 4095, 4095);
        send_clip(4095, 4095, 0, 0);
        send_clip(100, 200, 100, 200);
        send_load(1, 2000, 0);
        send_load(2, 2000, 2000);
        send_load(3, 0, 2000);
        send_clip(4095, 1000, 0, 1000);
        send_clip(3000, 3000, 3000, 3000);
        send_clip(2500, 0, 2500, 4095);
        send_clip(2000, 0, 2000, 2000);
        send_clip(0, 4095, 4095, 0);
        send_clip(1, 2, 1999, 3);
        send_load(3, 2000, 2000);
        write_count(5'd31);
        send_clip(5, 5, 6, 6);
        write_count(5'd2);
        send_clip(5, 5, 6, 6);

        // Long receiver hold-off while items keep coming.
        write_count(5'd4);
        hold_off = 1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 10; i++)
                send_clip($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095));
        join

        k = 0;
        while (k < 1650)
        begin
            n = $urandom_range(0, 3) == 0 ? 16 : $urandom_range(3, 8);
            write_count(5'd0);
            load_polygon(n);
            write_count(5'($urandom_range(0, 7) == 0 ? 16 + $urandom_range(0, 15) : n));
            k += n;
            for (int i = 0; i < 40; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_clip($urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 4095), $urandom_range(0, 4095));
                else if ($urandom_range(0, 9) == 0)
                    send_load(16, 0, 0);
                else
                begin
                    send_clip(near_coord(int'(shape_x[i % n])),
                              near_coord(int'(shape_y[i % n])),
                              near_coord(int'(shape_x[(i + 3) % n])),
                              near_coord(int'(shape_y[(i + 3) % n])));
                end
                k++;
            end
        end
        req_valid <= 1'b0;
        sending_done = 1;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/cpc_pkg.sv
rtl/cpc_cell.sv
rtl/cpc_lane.sv
rtl/convex_polygon_line_clipper.sv
tb/tb_convex_polygon_line_clipper.sv
